/* hw/rtl/rotating_heater_budget_scheduler_unit_macros.svh */
// Assertion macros used by the heater budget scheduler sequencer.
`ifndef ROTATING_HEATER_BUDGET_SCHEDULER_UNIT_MACROS_SVH
`define ROTATING_HEATER_BUDGET_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication under active-low reset.
`define RHBS_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhbs assertion failed");

// Next-cycle implication under active-low reset.
`define RHBS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhbs assertion failed");

`endif

/* hw/rtl/rhbs_pkg.sv */
// Shared types, register codes and reset values of the heater budget scheduler.
package rhbs_pkg;

  localparam int unsigned MAX_HEATERS_DEF = 8;
  localparam int unsigned TIME_BITS_DEF   = 32;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [31:0] MIN_HEAT_RST = 32'd5000;
  localparam logic [31:0] MAX_HEAT_RST = 32'd60000;
  localparam logic [3:0]  MAX_SIMUL_RST = 4'd1;
  localparam logic [3:0]  WIN_OFFSET_RST = 4'd1;
  localparam logic [2:0]  RANGE_START_RST = 3'd0;
  localparam logic [2:0]  RANGE_END_RST = 3'd7;

  typedef enum logic [2:0] {
    REG_ENABLE,
    REG_DEVICE_COUNT,
    REG_MIN_HEAT,
    REG_MAX_HEAT,
    REG_MAX_SIMUL,
    REG_WIN_OFFSET,
    REG_RANGE_START,
    REG_RANGE_END
  } reg_idx_e;

  typedef struct packed {
    logic        enable;
    logic [3:0]  device_count;
    logic [31:0] min_heat_ms;
    logic [31:0] max_heat_ms;
    logic [3:0]  max_simultaneous;
    logic [3:0]  window_offset;
    logic [2:0]  range_start;
    logic [2:0]  range_end;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic walk;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_walk;
    logic walk_done;
  } status_t;

endpackage

/* hw/rtl/rotating_heater_budget_scheduler_unit.sv */
// Top level of the rotating heater budget scheduler.
// Input channel: one word per heater update (heater_index_i, now_ms_i,
//   heat_request_i), taken when in_valid_i and in_ready_o are both high.
// Output channel: one result word per input word (start, stop, heater_on,
//   window start, heating map), taken when out_valid_o and out_ready_i are high.
// Configuration: APB writes at byte address 4*i; each write clears all heating
//   flags and moves the window start to range_start in the cycle after the write.
// Sequence: after the word is taken, the evaluate state checks stop and minimum
//   time, the walk state moves the window start one range index per step (only
//   when the window-start heater stops), and the decide state decides the start
//   and loads the result register.
// Flow: a new word is taken only once the previous one sits in the result
//   register; the walk sequencer holds in_ready_o low until then.
// Reset: heating flags clear, window start is 0, configuration takes its
//   reset values and no result is pending.
// Stall: a held result stays in the result register; the next word may be
//   taken and evaluated, then waits before commit until the register frees.
module rotating_heater_budget_scheduler_unit #(
  parameter int unsigned MAX_HEATERS = rhbs_pkg::MAX_HEATERS_DEF,
  parameter int unsigned TIME_BITS   = rhbs_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rhbs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rhbs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rhbs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [2:0]                       heater_index_i,
  input  logic [31:0]                      now_ms_i,
  input  logic                             heat_request_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             start_command_o,
  output logic                             stop_command_o,
  output logic                             heater_on_o,
  output logic [2:0]                       window_start_o,
  output logic [7:0]                       heating_map_o
);

  rhbs_pkg::cfg_t    cfg;
  logic              cfg_clear;
  rhbs_pkg::cmd_t    cmd;
  rhbs_pkg::status_t status;

  rhbs_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .cfg_clear_o (cfg_clear)
  );

  rhbs_datapath #(
    .MAX_HEATERS (MAX_HEATERS),
    .TIME_BITS   (TIME_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cfg_clear_i     (cfg_clear),
    .cmd_i           (cmd),
    .status_o        (status),
    .heater_index_i  (heater_index_i),
    .now_ms_i        (now_ms_i),
    .heat_request_i  (heat_request_i),
    .start_command_o (start_command_o),
    .stop_command_o  (stop_command_o),
    .heater_on_o     (heater_on_o),
    .window_start_o  (window_start_o),
    .heating_map_o   (heating_map_o)
  );

  rhbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

endmodule

/* hw/rtl/rhbs_regs.sv */
// APB configuration registers with the clear pulse that follows each write.
module rhbs_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rhbs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rhbs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rhbs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output rhbs_pkg::cfg_t                      cfg_o,
  output logic                                cfg_clear_o
);

  rhbs_pkg::cfg_t     cfg_q;
  logic               clear_q;
  logic               wr;
  rhbs_pkg::reg_idx_e ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign ridx   = rhbs_pkg::reg_idx_e'(paddr[rhbs_pkg::APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable           <= 1'b0;
      cfg_q.device_count     <= 4'd0;
      cfg_q.min_heat_ms      <= rhbs_pkg::MIN_HEAT_RST;
      cfg_q.max_heat_ms      <= rhbs_pkg::MAX_HEAT_RST;
      cfg_q.max_simultaneous <= rhbs_pkg::MAX_SIMUL_RST;
      cfg_q.window_offset    <= rhbs_pkg::WIN_OFFSET_RST;
      cfg_q.range_start      <= rhbs_pkg::RANGE_START_RST;
      cfg_q.range_end        <= rhbs_pkg::RANGE_END_RST;
      clear_q                <= 1'b0;
    end else begin
      clear_q <= wr;
      if (wr) begin
        case (ridx)
          rhbs_pkg::REG_ENABLE:       cfg_q.enable           <= pwdata[0];
          rhbs_pkg::REG_DEVICE_COUNT: cfg_q.device_count     <= pwdata[3:0];
          rhbs_pkg::REG_MIN_HEAT:     cfg_q.min_heat_ms      <= pwdata[31:0];
          rhbs_pkg::REG_MAX_HEAT:     cfg_q.max_heat_ms      <= pwdata[31:0];
          rhbs_pkg::REG_MAX_SIMUL:    cfg_q.max_simultaneous <= pwdata[3:0];
          rhbs_pkg::REG_WIN_OFFSET:   cfg_q.window_offset    <= pwdata[3:0];
          rhbs_pkg::REG_RANGE_START:  cfg_q.range_start      <= pwdata[2:0];
          rhbs_pkg::REG_RANGE_END:    cfg_q.range_end        <= pwdata[2:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (ridx)
      rhbs_pkg::REG_ENABLE:       prdata = 32'(cfg_q.enable);
      rhbs_pkg::REG_DEVICE_COUNT: prdata = 32'(cfg_q.device_count);
      rhbs_pkg::REG_MIN_HEAT:     prdata = cfg_q.min_heat_ms;
      rhbs_pkg::REG_MAX_HEAT:     prdata = cfg_q.max_heat_ms;
      rhbs_pkg::REG_MAX_SIMUL:    prdata = 32'(cfg_q.max_simultaneous);
      rhbs_pkg::REG_WIN_OFFSET:   prdata = 32'(cfg_q.window_offset);
      rhbs_pkg::REG_RANGE_START:  prdata = 32'(cfg_q.range_start);
      rhbs_pkg::REG_RANGE_END:    prdata = 32'(cfg_q.range_end);
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o       = cfg_q;
  assign cfg_clear_o = clear_q;

endmodule

/* hw/rtl/rhbs_datapath.sv */
// Heater flags, start times, window start and the per-word decision logic.
module rhbs_datapath #(
  parameter int unsigned MAX_HEATERS = rhbs_pkg::MAX_HEATERS_DEF,
  parameter int unsigned TIME_BITS   = rhbs_pkg::TIME_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rhbs_pkg::cfg_t     cfg_i,
  input  logic               cfg_clear_i,
  input  rhbs_pkg::cmd_t     cmd_i,
  output rhbs_pkg::status_t  status_o,
  input  logic [2:0]         heater_index_i,
  input  logic [31:0]        now_ms_i,
  input  logic               heat_request_i,
  output logic               start_command_o,
  output logic               stop_command_o,
  output logic               heater_on_o,
  output logic [2:0]         window_start_o,
  output logic [7:0]         heating_map_o
);

  localparam int unsigned NumSlots = (MAX_HEATERS < 8) ? MAX_HEATERS : 8;
  localparam int unsigned SlotW    = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned CmpW     = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam logic [4:0]  MaxIdx   = 5'(MAX_HEATERS);

  logic [NumSlots-1:0]  flags_q;
  logic [TIME_BITS-1:0] start_q [NumSlots];
  logic [2:0]           window_q;

  logic [2:0]           idx_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 req_q;
  logic                 valid_q;
  logic                 stop_q;
  logic                 hold_q;
  logic [2:0]           next_q;
  logic [3:0]           moved_q;

  logic                 start_o_q;
  logic                 stop_o_q;
  logic                 heater_on_q;
  logic [2:0]           window_o_q;
  logic [7:0]           map_q;

  logic [SlotW-1:0]     slot;
  logic                 idx_ok;
  logic [3:0]           rs4;
  logic [3:0]           re1;
  logic [3:0]           hi;
  logic [3:0]           active;
  logic [3:0]           eff;
  logic [3:0]           span;
  logic                 valid_c;
  logic [TIME_BITS-1:0] elapsed;
  logic                 stop_c;
  logic                 hold_c;
  logic [3:0]           nxt4;
  logic [2:0]           nsel;
  logic [3:0]           moved_inc;
  logic                 walk_done;
  logic [3:0]           win_gap;
  logic                 in_win;
  logic                 start_c;
  logic [NumSlots-1:0]  flags_nx;
  logic [7:0]           map_nx;

  assign slot   = idx_q[SlotW-1:0];
  assign idx_ok = {2'b00, idx_q} < MaxIdx;

  // range occupancy
  assign rs4    = {1'b0, cfg_i.range_start};
  assign re1    = {1'b0, cfg_i.range_end} + 4'd1;
  assign hi     = (re1 < cfg_i.device_count) ? re1 : cfg_i.device_count;
  assign active = ((cfg_i.range_start > cfg_i.range_end) || (cfg_i.device_count <= rs4))
                  ? 4'd0 : (hi - rs4);
  assign eff    = (cfg_i.max_simultaneous > active) ? active : cfg_i.max_simultaneous;
  assign span   = re1 - rs4;

  // stop and minimum-time decision
  assign valid_c = cfg_i.enable && (cfg_i.device_count != 4'd0) &&
                   ({1'b0, idx_q} < cfg_i.device_count) &&
                   (idx_q >= cfg_i.range_start) && (idx_q <= cfg_i.range_end) && idx_ok;
  assign elapsed = now_q - start_q[slot];
  assign stop_c  = valid_c && flags_q[slot] &&
                   (!req_q || (CmpW'(elapsed) >= CmpW'(cfg_i.max_heat_ms)));
  assign hold_c  = valid_c && flags_q[slot] && !stop_c &&
                   (CmpW'(elapsed) < CmpW'(cfg_i.min_heat_ms));

  // one step of the window start walk
  assign nxt4      = {1'b0, next_q} + 4'd1;
  assign nsel      = (nxt4 > {1'b0, cfg_i.range_end}) ? cfg_i.range_start : nxt4[2:0];
  assign moved_inc = moved_q + 4'({1'b0, nsel} < cfg_i.device_count);
  assign walk_done = (moved_inc >= cfg_i.window_offset) || (nsel == window_q);

  assign status_o.need_walk = stop_c && (idx_q == window_q) && (active != 4'd0) &&
                              (cfg_i.window_offset != 4'd0);
  assign status_o.walk_done = walk_done;

  // window membership and start decision
  always_comb begin
    win_gap = {1'b0, idx_q} - {1'b0, window_q};
    if (idx_q < window_q) begin
      win_gap = win_gap + span;
    end
  end

  assign in_win   = win_gap < eff;
  assign start_c  = valid_q && !hold_q && !flags_q[slot] && in_win && req_q;
  assign flags_nx = flags_q | (start_c ? (NumSlots'(1) << slot) : '0);

  for (genvar i = 0; i < 8; i++) begin : g_map
    if (i < NumSlots) begin : g_live
      assign map_nx[i] = flags_nx[i];
    end else begin : g_none
      assign map_nx[i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= '0;
      window_q <= rhbs_pkg::RANGE_START_RST;
    end else if (cfg_clear_i) begin
      flags_q  <= '0;
      window_q <= cfg_i.range_start;
    end else begin
      if (cmd_i.eval && stop_c) begin
        flags_q[slot] <= 1'b0;
      end
      if (cmd_i.walk && walk_done) begin
        window_q <= nsel;
      end
      if (cmd_i.commit) begin
        flags_q <= flags_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= heater_index_i;
      now_q <= TIME_BITS'(now_ms_i);
      req_q <= heat_request_i;
    end
    if (cmd_i.eval) begin
      valid_q <= valid_c;
      stop_q  <= stop_c;
      hold_q  <= hold_c;
      next_q  <= window_q;
      moved_q <= 4'd0;
    end
    if (cmd_i.walk) begin
      next_q  <= nsel;
      moved_q <= moved_inc;
    end
    if (cmd_i.commit) begin
      if (start_c) begin
        start_q[slot] <= now_q;
      end
      start_o_q   <= start_c;
      stop_o_q    <= stop_q;
      heater_on_q <= idx_ok && (flags_q[slot] || start_c);
      window_o_q  <= window_q;
      map_q       <= map_nx;
    end
  end

  assign start_command_o = start_o_q;
  assign stop_command_o  = stop_o_q;
  assign heater_on_o     = heater_on_q;
  assign window_start_o  = window_o_q;
  assign heating_map_o   = map_q;

endmodule

/* hw/rtl/rhbs_ctrl.sv */
// Sequencer that steps one word through evaluate, window walk and commit.
`include "rotating_heater_budget_scheduler_unit_macros.svh"

module rhbs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  rhbs_pkg::status_t  status_i,
  output rhbs_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WALK,
    ST_DECIDE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  assign cmd_o.load   = in_valid_i && in_ready_o;
  assign cmd_o.eval   = (state_q == ST_EVAL);
  assign cmd_o.walk   = (state_q == ST_WALK);
  assign cmd_o.commit = (state_q == ST_DECIDE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state_q <= status_i.need_walk ? ST_WALK : ST_DECIDE;
        end
        ST_WALK: begin
          if (status_i.walk_done) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  `RHBS_ASSERT_NEXT(a_accept_to_eval, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_EVAL)
  `RHBS_ASSERT_NEXT(a_commit_shows_word, clk_i, rst_ni, cmd_o.commit, out_valid_q && in_ready_o)
  `RHBS_ASSERT_SAME(a_busy_not_ready, clk_i, rst_ni, cmd_o.eval || cmd_o.walk, !in_ready_o)
  `RHBS_ASSERT_NEXT(a_stall_holds_decide, clk_i, rst_ni, (state_q == ST_DECIDE) && !out_free, state_q == ST_DECIDE && out_valid_q)

endmodule

/* test/tb.sv */
// Self-checking testbench for the rotating heater budget scheduler unit.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned WALK_GUARD  = 64;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct {
    logic [2:0]  idx;
    logic [31:0] now;
    logic        req;
  } heater_word_t;

  typedef struct {
    logic       start_cmd;
    logic       stop_cmd;
    logic       heater_on;
    logic [2:0] window_start;
    logic [7:0] heating_map;
  } heater_result_t;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [rhbs_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [rhbs_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [rhbs_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [2:0]                      heater_index_i = '0;
  logic [31:0]                     now_ms_i = '0;
  logic                            heat_request_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic                            start_command_o;
  logic                            stop_command_o;
  logic                            heater_on_o;
  logic [2:0]                      window_start_o;
  logic [7:0]                      heating_map_o;

  heater_word_t   pend_q[$];
  heater_result_t sched_exp_q[$];

  rhbs_pkg::cfg_t cfg;
  logic [7:0]     heat_on;
  logic [31:0]    on_since[8];
  logic [2:0]     win_idx;

  logic [31:0] clock_ms;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          in_taken = 1'b0;

  rotating_heater_budget_scheduler_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .heater_index_i  (heater_index_i),
    .now_ms_i        (now_ms_i),
    .heat_request_i  (heat_request_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .start_command_o (start_command_o),
    .stop_command_o  (stop_command_o),
    .heater_on_o     (heater_on_o),
    .window_start_o  (window_start_o),
    .heating_map_o   (heating_map_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int unsigned devices_in_span();
    int unsigned n = 0;
    if (cfg.range_start > cfg.range_end) return 0;
    for (int unsigned i = cfg.range_start; i <= cfg.range_end; i++) begin
      if (i < cfg.device_count) n++;
    end
    return n;
  endfunction

  function automatic bit in_rotation_window(int unsigned idx);
    int unsigned active, eff, count, pos, guard;
    active = devices_in_span();
    if (cfg.device_count == 0 || active == 0) return 1'b0;
    if (idx < cfg.range_start || idx > cfg.range_end) return 1'b0;
    eff = (cfg.max_simultaneous > active) ? active : cfg.max_simultaneous;
    count = 0;
    pos = win_idx;
    guard = 0;
    while (count < eff && guard < WALK_GUARD) begin
      guard++;
      if (pos == idx) return 1'b1;
      count++;
      pos++;
      if (pos > cfg.range_end) pos = cfg.range_start;
      if (pos == win_idx && count < eff) break;
    end
    return 1'b0;
  endfunction

  function automatic void rotate_window_start();
    int unsigned moved, nxt, guard;
    if (devices_in_span() == 0) return;
    moved = 0;
    nxt = win_idx;
    guard = 0;
    while (moved < cfg.window_offset && guard < WALK_GUARD) begin
      guard++;
      nxt++;
      if (nxt > cfg.range_end) nxt = cfg.range_start;
      if (nxt < cfg.device_count) moved++;
      if (nxt == win_idx && moved < cfg.window_offset) break;
    end
    win_idx = nxt[2:0];
  endfunction

  function automatic heater_result_t predict_heater_update(heater_word_t w);
    heater_result_t r;
    bit             active, hold;
    logic [31:0]    elapsed;
    r.start_cmd = 1'b0;
    r.stop_cmd = 1'b0;
    hold = 1'b0;
    active = cfg.enable && cfg.device_count != 0 && w.idx < cfg.device_count &&
             w.idx >= cfg.range_start && w.idx <= cfg.range_end;
    if (active) begin
      if (heat_on[w.idx]) begin
        elapsed = w.now - on_since[w.idx];
        if (!w.req || elapsed >= cfg.max_heat_ms) begin
          heat_on[w.idx] = 1'b0;
          r.stop_cmd = 1'b1;
          if (w.idx == win_idx) rotate_window_start();
        end else if (elapsed < cfg.min_heat_ms) begin
          hold = 1'b1;
        end
      end
      if (!hold && !heat_on[w.idx] && in_rotation_window(w.idx) && w.req) begin
        heat_on[w.idx] = 1'b1;
        on_since[w.idx] = w.now;
        r.start_cmd = 1'b1;
      end
    end
    r.heater_on = heat_on[w.idx];
    r.window_start = win_idx;
    r.heating_map = heat_on;
    return r;
  endfunction

  function automatic void apply_register(rhbs_pkg::reg_idx_e r, logic [31:0] v);
    case (r)
      rhbs_pkg::REG_ENABLE:       cfg.enable = v[0];
      rhbs_pkg::REG_DEVICE_COUNT: cfg.device_count = v[3:0];
      rhbs_pkg::REG_MIN_HEAT:     cfg.min_heat_ms = v;
      rhbs_pkg::REG_MAX_HEAT:     cfg.max_heat_ms = v;
      rhbs_pkg::REG_MAX_SIMUL:    cfg.max_simultaneous = v[3:0];
      rhbs_pkg::REG_WIN_OFFSET:   cfg.window_offset = v[3:0];
      rhbs_pkg::REG_RANGE_START:  cfg.range_start = v[2:0];
      rhbs_pkg::REG_RANGE_END:    cfg.range_end = v[2:0];
      default: ;
    endcase
    heat_on = '0;
    win_idx = cfg.range_start;
  endfunction

  function automatic void compare_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endfunction

  task automatic apb_write(rhbs_pkg::reg_idx_e r, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_register(r, v);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || in_valid_i || sched_exp_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic load_settings(logic en, logic [3:0] dc, logic [31:0] mn, logic [31:0] mx,
                               logic [3:0] ms, logic [3:0] wo, logic [2:0] rs,
                               logic [2:0] re);
    wait_drained();
    apb_write(rhbs_pkg::REG_ENABLE, {31'd0, en});
    apb_write(rhbs_pkg::REG_DEVICE_COUNT, {28'd0, dc});
    apb_write(rhbs_pkg::REG_MIN_HEAT, mn);
    apb_write(rhbs_pkg::REG_MAX_HEAT, mx);
    apb_write(rhbs_pkg::REG_MAX_SIMUL, {28'd0, ms});
    apb_write(rhbs_pkg::REG_WIN_OFFSET, {28'd0, wo});
    apb_write(rhbs_pkg::REG_RANGE_START, {29'd0, rs});
    apb_write(rhbs_pkg::REG_RANGE_END, {29'd0, re});
    repeat (2) @(posedge clk_i);
  endtask

  task automatic push_word(logic [2:0] idx, logic [31:0] now, logic req);
    heater_word_t w;
    w.idx = idx;
    w.now = now;
    w.req = req;
    pend_q.insert(pend_q.size(), w);
  endtask

  task automatic queue_random_words(int unsigned n);
    int unsigned lo, hi, sel, step_cap;
    lo = cfg.range_start;
    hi = cfg.range_end;
    if (cfg.device_count != 0 && hi >= cfg.device_count) hi = cfg.device_count - 1;
    step_cap = (cfg.max_heat_ms < 1000) ? cfg.max_heat_ms / 8 + 2 : 25;
    for (int unsigned k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 3) clock_ms = $urandom;
      else if (sel < 10) clock_ms += $urandom_range(1000);
      else clock_ms += $urandom_range(step_cap);
      if ($urandom_range(99) < 85 && lo <= hi)
        push_word(3'($urandom_range(hi, lo)), clock_ms, $urandom_range(99) < 80);
      else
        push_word(3'($urandom_range(7)), clock_ms, $urandom_range(99) < 80);
    end
  endtask

  task automatic run_batch(logic en, logic [3:0] dc, logic [31:0] mn, logic [31:0] mx,
                           logic [3:0] ms, logic [3:0] wo, logic [2:0] rs, logic [2:0] re,
                           int unsigned n, idle_mode_e mode);
    load_settings(en, dc, mn, mx, ms, wo, rs, re);
    send_idle_pct = (mode == IDLE_SEND) ? 53 : (mode == IDLE_BOTH) ? 14 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 53 : (mode == IDLE_BOTH) ? 14 : 0;
    queue_random_words(n);
  endtask

  always @(negedge clk_i) begin
    heater_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      if (!in_valid_i || in_taken) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pend_q.pop_front();
          heater_index_i <= w.idx;
          now_ms_i <= w.now;
          heat_request_i <= w.req;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    heater_result_t want;
    heater_word_t   seen;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (sched_exp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result word with none expected, map %0h", $time, heating_map_o);
        end else begin
          want = sched_exp_q.pop_front();
          compare_field("start_command", want.start_cmd, start_command_o);
          compare_field("stop_command", want.stop_cmd, stop_command_o);
          compare_field("heater_on", want.heater_on, heater_on_o);
          compare_field("window_start", want.window_start, window_start_o);
          compare_field("heating_map", want.heating_map, heating_map_o);
        end
      end
      in_taken = in_valid_i && in_ready_o;
      if (in_taken) begin
        seen.idx = heater_index_i;
        seen.now = now_ms_i;
        seen.req = heat_request_i;
        sched_exp_q.insert(sched_exp_q.size(), predict_heater_update(seen));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("rotating_heater_budget_scheduler_unit test failed");
      $finish;
    end
  end

  initial begin
    logic [2:0]  rs_v, re_v, swap_v;
    logic [3:0]  dc_v;
    cfg = '{enable: 1'b0, device_count: 4'd0, min_heat_ms: rhbs_pkg::MIN_HEAT_RST,
            max_heat_ms: rhbs_pkg::MAX_HEAT_RST, max_simultaneous: rhbs_pkg::MAX_SIMUL_RST,
            window_offset: rhbs_pkg::WIN_OFFSET_RST, range_start: rhbs_pkg::RANGE_START_RST,
            range_end: rhbs_pkg::RANGE_END_RST};
    heat_on = '0;
    for (int i = 0; i < 8; i++) on_since[i] = '0;
    win_idx = rhbs_pkg::RANGE_START_RST;
    clock_ms = $urandom;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_word(3'd0, 32'd0, 1'b1);
    load_settings(1'b1, 4'd8, 32'd10, 32'd100, 4'd2, 4'd1, 3'd0, 3'd7);
    push_word(3'd0, 32'd0, 1'b1);
    push_word(3'd1, 32'd1, 1'b1);
    push_word(3'd2, 32'd2, 1'b1);
    push_word(3'd0, 32'd5, 1'b1);
    push_word(3'd0, 32'd6, 1'b0);
    push_word(3'd1, 32'd200, 1'b1);
    push_word(3'd2, 32'd210, 1'b1);
    push_word(3'd3, 32'd220, 1'b1);
    push_word(3'd3, 32'd400, 1'b1);
    push_word(3'd7, 32'd401, 1'b1);
    push_word(3'd7, 32'd402, 1'b0);
    push_word(3'd2, 32'hFFFF_FFF0, 1'b1);
    push_word(3'd4, 32'hFFFF_FFF8, 1'b1);
    push_word(3'd4, 32'h0000_0005, 1'b1);
    push_word(3'd4, 32'h0000_0060, 1'b1);
    push_word(3'd3, 32'h0000_0061, 1'b0);
    load_settings(1'b1, 4'd3, 32'd0, 32'hFFFF_FFFF, 4'd8, 4'd8, 3'd1, 3'd6);
    push_word(3'd0, 32'd0, 1'b1);
    push_word(3'd1, 32'd1, 1'b1);
    push_word(3'd2, 32'd2, 1'b1);
    push_word(3'd5, 32'd3, 1'b1);
    push_word(3'd1, 32'd4, 1'b0);
    push_word(3'd2, 32'd5, 1'b1);
    push_word(3'd2, 32'd6, 1'b0);

    run_batch(1'b1, 4'd8, 32'd20, 32'd100, 4'd3, 4'd1, 3'd0, 3'd7, 155, IDLE_NONE);
    run_batch(1'b1, 4'd8, 32'd0, 32'd0, 4'd8, 4'd8, 3'd0, 3'd7, 155, IDLE_SEND);
    run_batch(1'b1, 4'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd2, 4'd0, 3'd2, 3'd7, 155,
              IDLE_RECV);
    run_batch(1'b1, 4'd0, 32'd10, 32'd50, 4'd2, 4'd1, 3'd0, 3'd7, 40, IDLE_BOTH);
    run_batch(1'b1, 4'd8, 32'd0, 32'd50, 4'd1, 4'd3, 3'd5, 3'd2, 40, IDLE_NONE);
    run_batch(1'b0, 4'd8, 32'd5, 32'd60, 4'd4, 4'd2, 3'd0, 3'd7, 40, IDLE_SEND);
    run_batch(1'b1, 4'd3, 32'd15, 32'd90, 4'd0, 4'd2, 3'd1, 3'd6, 60, IDLE_RECV);
    run_batch(1'b1, 4'd3, 32'd15, 32'd90, 4'd4, 4'd2, 3'd1, 3'd6, 155, IDLE_BOTH);
    for (int unsigned p = 0; p < 7; p++) begin
      rs_v = 3'($urandom_range(7));
      re_v = 3'($urandom_range(7));
      if (rs_v > re_v && $urandom_range(3) != 0) begin
        swap_v = rs_v;
        rs_v = re_v;
        re_v = swap_v;
      end
      dc_v = 4'($urandom_range(8, 1));
      run_batch($urandom_range(9) != 0, dc_v, $urandom_range(40), $urandom_range(160),
                4'($urandom_range(8)), 4'($urandom_range(8)), rs_v, re_v, 155,
                idle_mode_e'(p % 4));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && sched_exp_q.size() == 0) begin
      $display("rotating_heater_budget_scheduler_unit test passed");
    end else begin
      $display("rotating_heater_budget_scheduler_unit test failed");
    end
    $finish;
  end

endmodule
